### rtl/core/dadv_pkg.sv
// Package for the date advance block: constants, state and status codes, calendar helpers.
`timescale 1ns / 1ps
package dadv_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned STAT_W  = 2;
  // day accumulator holds day + count before the walk
  localparam int unsigned ACC_W   = 17;
  localparam int unsigned MOD25_W = 5;

  localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [DAY_W-1:0]   DAY_SAT   = 5'd31;

  // reciprocal of 25 scaled by 2^20, rounded up; exact for 14-bit years
  localparam logic [15:0] RECIP25     = 16'd41944;
  localparam int unsigned RECIP_SHIFT = 20;
  localparam logic [MOD25_W-1:0] MOD25_LAST = 5'd24;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_INVALID  = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_CHECK,
    ST_WALK,
    ST_FIN
  } state_t;

  // Gregorian leap rule from the low year bits and the year's remainder mod 25
  function automatic logic is_leap(input logic [3:0] y_low, input logic [MOD25_W-1:0] m25);
    logic div4;
    logic div16;
    logic div25;
    div4  = (y_low[1:0] == 2'b00);
    div16 = (y_low == 4'b0000);
    div25 = (m25 == '0);
    return div4 && (!div25 || div16);
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                 input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    case (m)
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd4,
      4'd6,
      4'd9,
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

### rtl/core/dadv_mod25.sv
// Year remainder mod 25 through a registered reciprocal multiply.
`timescale 1ns / 1ps
module dadv_mod25 (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [dadv_pkg::YEAR_W-1:0]   year,
  output logic                          done,
  output logic [dadv_pkg::MOD25_W-1:0]  rem
);

  localparam int unsigned PROD_W = dadv_pkg::YEAR_W + 16;
  localparam int unsigned QUO_W  = PROD_W - dadv_pkg::RECIP_SHIFT;

  logic [PROD_W-1:0]           prod;
  logic [dadv_pkg::YEAR_W-1:0] year_q;
  logic                        busy;
  logic [QUO_W-1:0]            quo;
  logic [dadv_pkg::YEAR_W-1:0] quo_w;
  logic [dadv_pkg::YEAR_W-1:0] diff;

  // control pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= start;
      done <= busy;
    end
  end

  // stage 1: quotient estimate by multiply
  always_ff @(posedge clk) begin
    prod   <= PROD_W'(year) * PROD_W'(dadv_pkg::RECIP25);
    year_q <= year;
  end

  // stage 2: remainder = year - 25 * quotient, by shifts and adds
  assign quo   = prod[PROD_W-1:dadv_pkg::RECIP_SHIFT];
  assign quo_w = dadv_pkg::YEAR_W'(quo);
  assign diff  = year_q - (quo_w << 4) - (quo_w << 3) - quo_w;

  always_ff @(posedge clk) begin
    rem <= diff[dadv_pkg::MOD25_W-1:0];
  end

endmodule

### rtl/core/date_advance_by_days.sv
// Top level: date advance sequencer with one shared compare/subtract month step.
// One item in flight: s_axis_tready is high only in idle, so no new beat is taken
// while the sequencer checks the date and walks the month boundaries.
// The result waits in an output register, freeing the sequencer for the next beat,
// which can be taken in the cycle after the result register loads.
// Reset (rst, synchronous, active high) clears the sequencer and output valid.
`timescale 1ns / 1ps
module date_advance_by_days (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [13:0] start_year, [17:14] start_month, [22:18] start_day, [38:23] days_to_add
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [13:0] end_year, [17:14] end_month, [22:18] end_day, [24:23] status
  output logic [31:0] m_axis_tdata
);

  localparam int unsigned YW = dadv_pkg::YEAR_W;
  localparam int unsigned MW = dadv_pkg::MONTH_W;
  localparam int unsigned DW = dadv_pkg::DAY_W;
  localparam int unsigned NW = dadv_pkg::COUNT_W;
  localparam int unsigned AW = dadv_pkg::ACC_W;
  localparam int unsigned RW = dadv_pkg::MOD25_W;

  dadv_pkg::state_t  state, state_next;
  logic [YW-1:0]     y, y_next;
  logic [MW-1:0]     m, m_next;
  logic [AW-1:0]     d, d_next;
  logic [NW-1:0]     n, n_next;
  logic [RW-1:0]     m25, m25_next;
  dadv_pkg::status_t st, st_next;
  logic              out_valid, out_valid_next;
  logic [31:0]       out_data, out_data_next;

  logic              mod_start;
  logic              mod_done;
  logic [RW-1:0]     mod_rem;
  logic              leap;
  logic [DW-1:0]     mlen;
  logic [AW-1:0]     mlen_w;
  logic              in_beat;
  logic              bad_date;

  dadv_mod25 u_mod25 (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .year  (s_axis_tdata[13:0]),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  // month length of the current walk position
  assign leap    = dadv_pkg::is_leap(y[3:0], m25);
  assign mlen    = dadv_pkg::month_len(leap, m);
  assign mlen_w  = AW'(mlen);
  assign in_beat = s_axis_tvalid && s_axis_tready;

  assign bad_date = (y == '0) || (y > dadv_pkg::YEAR_MAX) || (m == '0) ||
                    (m > dadv_pkg::MONTH_DEC) || (d == '0) || (d > mlen_w);

  assign s_axis_tready = (state == dadv_pkg::ST_IDLE);
  assign mod_start     = in_beat;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dadv_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    y        <= y_next;
    m        <= m_next;
    d        <= d_next;
    n        <= n_next;
    m25      <= m25_next;
    st       <= st_next;
    out_data <= out_data_next;
  end

  // sequencer: next state and datapath
  always_comb begin
    state_next     = state;
    y_next         = y;
    m_next         = m;
    d_next         = d;
    n_next         = n;
    m25_next       = m25;
    st_next        = st;
    out_data_next  = out_data;
    out_valid_next = out_valid;

    if (out_valid && m_axis_tready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      dadv_pkg::ST_IDLE: begin
        if (in_beat) begin
          y_next     = s_axis_tdata[13:0];
          m_next     = s_axis_tdata[17:14];
          d_next     = AW'(s_axis_tdata[22:18]);
          n_next     = s_axis_tdata[38:23];
          st_next    = dadv_pkg::STATUS_OK;
          state_next = dadv_pkg::ST_MOD;
        end
      end
      dadv_pkg::ST_MOD: begin
        if (mod_done) begin
          m25_next   = mod_rem;
          state_next = dadv_pkg::ST_CHECK;
        end
      end
      dadv_pkg::ST_CHECK: begin
        if (bad_date) begin
          st_next    = dadv_pkg::STATUS_INVALID;
          state_next = dadv_pkg::ST_FIN;
        end else begin
          d_next     = d + AW'(n);
          state_next = dadv_pkg::ST_WALK;
        end
      end
      dadv_pkg::ST_WALK: begin
        // one month per cycle through the shared compare/subtract
        if (d > mlen_w) begin
          d_next = d - mlen_w;
          if (m == dadv_pkg::MONTH_DEC) begin
            if (y == dadv_pkg::YEAR_MAX) begin
              d_next     = AW'(dadv_pkg::DAY_SAT);
              st_next    = dadv_pkg::STATUS_OVERFLOW;
              state_next = dadv_pkg::ST_FIN;
            end else begin
              m_next   = dadv_pkg::MONTH_JAN;
              y_next   = y + YW'(1);
              m25_next = (m25 == dadv_pkg::MOD25_LAST) ? '0 : m25 + RW'(1);
            end
          end else begin
            m_next = m + MW'(1);
          end
        end else begin
          state_next = dadv_pkg::ST_FIN;
        end
      end
      dadv_pkg::ST_FIN: begin
        if (!out_valid || m_axis_tready) begin
          out_data_next  = {7'd0, st, d[DW-1:0], m, y};
          out_valid_next = 1'b1;
          state_next     = dadv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = dadv_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
